// ===== rtl/iterated_running_sum_image_macros.svh =====
// ---------------------------------------------------------------------------
// iterated running sum image: assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef ITERATED_RUNNING_SUM_IMAGE_MACROS_SVH
`define ITERATED_RUNNING_SUM_IMAGE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IRSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irsi check failed");

// next-cycle implication, disabled in reset
`define IRSI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irsi check failed");

// invariant that holds on every clock out of reset
`define IRSI_ASSERT_ALW(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("irsi check failed");

`endif

// ===== rtl/irsi_pkg.sv =====
// ---------------------------------------------------------------------------
// irsi_pkg
// types, register codes and saturating add shared by the sum cells
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package irsi_pkg;

  localparam int SUM_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int X_ORDER_W = 3;
  localparam int Y_ORDER_W = 3;
  localparam int LINE_W    = 11;
  localparam int HEIGHT_W  = 13;

  localparam logic [X_ORDER_W-1:0] X_ORDER_RST = 3'd1;
  localparam logic [Y_ORDER_W-1:0] Y_ORDER_RST = 3'd1;
  localparam logic [LINE_W-1:0]    LINE_RST    = 11'd1024;
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RST  = 13'd1024;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORDER      = 2'd0,
    REG_Y_ORDER      = 2'd1,
    REG_LINE_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_idx_t;

  // one sample as it moves down the chain
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    ov;
    logic                    first_col;
    logic                    first_row;
    logic                    last;
    logic                    fault;
  } item_t;

  typedef struct packed {
    logic                    ov;
    logic signed [SUM_W-1:0] sum;
  } add_res_t;

  function automatic add_res_t sat_add(input logic signed [SUM_W-1:0] a,
                                       input logic signed [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    add_res_t         r;
    s     = a + b;
    r.ov  = (a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1]);
    r.sum = r.ov ? (a[SUM_W-1] ? SUM_MIN : SUM_MAX) : s;
    return r;
  endfunction

endpackage

// ===== rtl/irsi_ram.sv =====
// ---------------------------------------------------------------------------
// irsi_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/irsi_row_cell.sv =====
// ---------------------------------------------------------------------------
// irsi_row_cell
// one running sum along the row, holding its own accumulator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irsi_row_cell #(
  parameter int IDX     = 0,
  parameter int ORDER_W = 3,
  parameter int COL_W   = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  irsi_pkg::item_t      in_item,
  input  logic [COL_W-1:0]     in_col,
  input  logic [ORDER_W-1:0]   order,
  output logic                 out_valid,
  input  logic                 out_ready,
  output irsi_pkg::item_t      out_item,
  output logic [COL_W-1:0]     out_col
);
  import irsi_pkg::*;

  logic signed [SUM_W-1:0] acc;
  logic                    active;
  logic                    load;
  add_res_t                res;
  item_t                   item_next;

  assign active   = ORDER_W'(IDX) < order;
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    // accumulator counts as zero at the row start
    res       = sat_add(in_item.first_col ? '0 : acc, in_item.sum);
    item_next = in_item;
    if (active) begin
      item_next.sum = res.sum;
      item_next.ov  = in_item.ov | res.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && active) begin
        acc <= res.sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
      out_col  <= in_col;
    end
  end

endmodule

// ===== rtl/irsi_col_cell.sv =====
// ---------------------------------------------------------------------------
// irsi_col_cell
// one running sum down the column, accumulators held in a column ram
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module irsi_col_cell #(
  parameter int IDX       = 0,
  parameter int ORDER_W   = 3,
  parameter int COL_W     = 10,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pre_load,
  input  logic [COL_W-1:0]     pre_col,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  irsi_pkg::item_t      in_item,
  input  logic [COL_W-1:0]     in_col,
  input  logic [ORDER_W-1:0]   order,
  output logic                 out_valid,
  input  logic                 out_ready,
  output irsi_pkg::item_t      out_item,
  output logic [COL_W-1:0]     out_col
);
  import irsi_pkg::*;

  logic                    active;
  logic                    load;
  logic                    wr_en;
  logic [SUM_W-1:0]        ram_q;
  logic                    byp;
  logic signed [SUM_W-1:0] byp_data;
  logic signed [SUM_W-1:0] prev;
  add_res_t                res;
  item_t                   item_next;

  assign active   = ORDER_W'(IDX) < order;
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;
  assign wr_en    = load && active;

  // read is issued when the sample enters the stage ahead of this cell
  irsi_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_col_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_col),
    .wdata(res.sum),
    .re   (pre_load),
    .raddr(pre_col),
    .rdata(ram_q)
  );

  // a write to the same column in the read cycle bypasses the ram
  always_ff @(posedge clk) begin
    if (pre_load) begin
      byp      <= wr_en && (in_col == pre_col);
      byp_data <= res.sum;
    end
  end

  always_comb begin
    prev      = in_item.first_row ? '0 : (byp ? byp_data : ram_q);
    res       = sat_add(prev, in_item.sum);
    item_next = in_item;
    if (active) begin
      item_next.sum = res.sum;
      item_next.ov  = in_item.ov | res.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
      out_col  <= in_col;
    end
  end

endmodule

// ===== rtl/iterated_running_sum_image.sv =====
// ---------------------------------------------------------------------------
// iterated_running_sum_image
// pipeline: the row cells then the column cells, each a registered stage, from input to result
// throughput: one sample per cycle while m_axis_tready does not stall the output, set by one
//   add per cell and one column ram read and write per column cell each cycle
// reset: control, position and row sums cleared, orders 1, size 1024 x 1024;
//   column rams are not cleared, row 0 of each frame writes them first
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "iterated_running_sum_image_macros.svh"

module iterated_running_sum_image #(
  parameter int MAX_ORDER   = 4,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [irsi_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [irsi_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pixel_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sum_value
  output logic [irsi_pkg::SUM_W-1:0]           m_axis_tdata,
  // overflow, config_fault
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import irsi_pkg::*;

  localparam int ORDER_W = $clog2(MAX_ORDER + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int NCELL   = 2 * MAX_ORDER;

  logic [X_ORDER_W-1:0] x_order;
  logic [Y_ORDER_W-1:0] y_order;
  logic [LINE_W-1:0]    line_width;
  logic [HEIGHT_W-1:0]  frame_height;

  logic [COL_W-1:0]     col_pos;
  logic [ROW_W-1:0]     row_pos;

  logic [31:0]          w_lim;
  logic [31:0]          h_lim;
  logic [ORDER_W-1:0]   xo;
  logic [ORDER_W-1:0]   yo;
  logic                 last_col;
  logic                 last_row;
  logic                 fault;
  logic                 in_xfer;
  logic [SAMPLE_BITS-1:0] sample;

  logic                 vld   [NCELL+1];
  logic                 rdy   [NCELL+1];
  item_t                item  [NCELL+1];
  logic [COL_W-1:0]     col   [NCELL+1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_order      <= X_ORDER_RST;
      y_order      <= Y_ORDER_RST;
      line_width   <= LINE_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_X_ORDER:      x_order      <= cfg_data[X_ORDER_W-1:0];
        REG_Y_ORDER:      y_order      <= cfg_data[Y_ORDER_W-1:0];
        REG_LINE_WIDTH:   line_width   <= cfg_data[LINE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes and orders
  always_comb begin
    if (line_width == '0) begin
      w_lim = 32'd1;
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      w_lim = 32'(MAX_WIDTH);
    end else begin
      w_lim = 32'(line_width);
    end
    if (frame_height == '0) begin
      h_lim = 32'd1;
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_lim = 32'(MAX_HEIGHT);
    end else begin
      h_lim = 32'(frame_height);
    end
    xo = (32'(x_order) > 32'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : ORDER_W'(x_order);
    yo = (32'(y_order) > 32'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : ORDER_W'(y_order);
  end

  assign last_col = (32'(col_pos) + 32'd1) >= w_lim;
  assign last_row = (32'(row_pos) + 32'd1) >= h_lim;
  assign fault    = (xo == '0) && (yo == '0);
  assign sample   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // raster position of the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : ROW_W'(32'(row_pos) + 32'd1);
      end else begin
        col_pos <= COL_W'(32'(col_pos) + 32'd1);
      end
    end
  end

  // head of the chain, a faulted sample enters as zero and no cell is active
  always_comb begin
    item[0].sum       = fault ? '0
                        : {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    item[0].ov        = 1'b0;
    item[0].first_col = (col_pos == '0);
    item[0].first_row = (row_pos == '0);
    item[0].last      = last_col && last_row;
    item[0].fault     = fault;
  end

  assign vld[0]        = s_axis_tvalid;
  assign col[0]        = col_pos;
  assign s_axis_tready = rdy[0];
  assign rdy[NCELL]    = m_axis_tready;

  for (genvar s = 0; s < MAX_ORDER; s++) begin : g_row
    irsi_row_cell #(
      .IDX    (s),
      .ORDER_W(ORDER_W),
      .COL_W  (COL_W)
    ) u_row_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld[s]),
      .in_ready (rdy[s]),
      .in_item  (item[s]),
      .in_col   (col[s]),
      .order    (xo),
      .out_valid(vld[s+1]),
      .out_ready(rdy[s+1]),
      .out_item (item[s+1]),
      .out_col  (col[s+1])
    );
  end

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_col
    irsi_col_cell #(
      .IDX      (k),
      .ORDER_W  (ORDER_W),
      .COL_W    (COL_W),
      .MAX_WIDTH(MAX_WIDTH)
    ) u_col_cell (
      .clk      (clk),
      .rst      (rst),
      .pre_load (vld[MAX_ORDER+k-1] && rdy[MAX_ORDER+k-1]),
      .pre_col  (col[MAX_ORDER+k-1]),
      .in_valid (vld[MAX_ORDER+k]),
      .in_ready (rdy[MAX_ORDER+k]),
      .in_item  (item[MAX_ORDER+k]),
      .in_col   (col[MAX_ORDER+k]),
      .order    (yo),
      .out_valid(vld[MAX_ORDER+k+1]),
      .out_ready(rdy[MAX_ORDER+k+1]),
      .out_item (item[MAX_ORDER+k+1]),
      .out_col  (col[MAX_ORDER+k+1])
    );
  end

  assign m_axis_tvalid = vld[NCELL];
  assign m_axis_tdata  = item[NCELL].sum;
  assign m_axis_tuser  = {item[NCELL].fault, item[NCELL].ov};
  assign m_axis_tlast  = item[NCELL].last;

  // checks
  `IRSI_ASSERT_IMP(a_fault_zero, clk, rst, m_axis_tvalid && m_axis_tuser[1],
                   (m_axis_tdata == '0) && !m_axis_tuser[0])
  `IRSI_ASSERT_NXT(a_frame_wrap, clk, rst, in_xfer && last_col && last_row,
                   (col_pos == '0) && (row_pos == '0))
  `IRSI_ASSERT_ALW(a_pos_range, clk, rst,
                   (32'(col_pos) < 32'(MAX_WIDTH)) && (32'(row_pos) < 32'(MAX_HEIGHT)))

endmodule
